@@ rtl/core/xrng_pkg.sv @@
`default_nettype none
package xrng_pkg;
    localparam logic [1:0] ACT_RESEED = 2'd0;
    localparam logic [1:0] ACT_RAW = 2'd1;
    localparam logic [1:0] ACT_BELOW = 2'd2;
    localparam logic [1:0] ACT_RANGE = 2'd3;
    localparam logic [63:0] DEFAULT_SEED = 64'h0123456789ABCDEF;
    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;

    typedef struct packed {
        logic load;
        logic sm_start;
        logic raw_start;
        logic div_start;
        logic div_floor;
        logic out_zero;
        logic out_lo;
        logic out_raw;
        logic out_mod;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic bound_zero;
        logic range_empty;
        logic reject;
        logic is_reseed;
        logic is_raw;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/core/xrng_if.sv @@
`default_nettype none
interface xrng_req_if;
    logic valid;
    logic ready;
    logic [1:0] action;
    logic [63:0] bound;
    logic [31:0] low_end;
    logic [31:0] high_end;
    modport source(output valid, action, bound, low_end, high_end, input ready);
    modport sink(input valid, action, bound, low_end, high_end, output ready);
endinterface

interface xrng_res_if;
    logic valid;
    logic ready;
    logic [63:0] value;
    modport source(output valid, value, input ready);
    modport sink(input valid, value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/xoshiro256ss_bounded_rng_core.sv @@
// xoshiro256** generator with bounded draws.
// i_req carries action, bound, low_end and high_end; o_res returns one value
// per request. Actions: reseed, raw draw, draw below bound, inclusive range.
// Configuration: i_seed_we writes i_seed_value, used by the next reseed.
// One request is handled at a time; ready is high when the block is idle
// and no result is waiting, so the next request is taken only after a
// result has been accepted by a ready receiver.
// A bounded draw runs a restoring divider for the rejection floor, draws
// outputs until one is not rejected and divides it again for the remainder.
// A zero bound or an empty range returns a result without a draw.
// After reset the state is expanded from the default seed; the first
// request can be taken once that expansion has finished.
// When the receiver stalls, the result holds and no new request is taken.
`default_nettype none
module xoshiro256ss_bounded_rng_core (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_seed_we,
    input wire logic [63:0] i_seed_value,
    xrng_req_if.sink i_req,
    xrng_res_if.source o_res
);
    xrng_pkg::t_cmd cmd;
    xrng_pkg::t_stat stat;
    logic [63:0] r_seed;
    logic empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= 64'd0;
        else if (i_seed_we) r_seed <= i_seed_value;
    end

    xrng_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seed(r_seed),
        .i_action(i_req.action), .i_bound(i_req.bound),
        .i_low_end(i_req.low_end), .i_high_end(i_req.high_end),
        .i_cmd(cmd), .o_stat(stat), .o_value(o_res.value)
    );

    assign empty = stat.range_empty;

    xrng_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(i_req), .res(o_res),
        .i_empty(empty),
        .i_stat(stat), .o_cmd(cmd)
    );
endmodule
`default_nettype wire

@@ rtl/core/xrng_datapath.sv @@
`default_nettype none
module xrng_datapath (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic [63:0] i_seed,
    input wire logic [1:0] i_action,
    input wire logic [63:0] i_bound,
    input wire logic [31:0] i_low_end,
    input wire logic [31:0] i_high_end,
    input wire xrng_pkg::t_cmd i_cmd,
    output xrng_pkg::t_stat o_stat,
    output logic [63:0] o_value
);
    // Multicycle units: splitmix (4 words, multiplies split into 32-bit partial
    // products), xoshiro step, restoring divider one quotient bit a cycle.
    logic [63:0] r_s0, r_s1, r_s2, r_s3;
    logic [63:0] r_n, r_x, r_lo;
    logic [31:0] r_hi;
    logic [1:0] r_act;
    logic [63:0] r_acc, r_z, r_pll;
    logic [31:0] r_px;
    logic [2:0] r_sm_ph;
    logic [1:0] r_sm_idx;
    logic r_sm_busy;
    logic [1:0] r_raw_ph;
    logic [63:0] r_rt;
    logic r_raw_busy;
    logic [64:0] r_rem;
    logic [63:0] r_dvd;
    logic [6:0] r_dcnt;
    logic r_div_busy;
    logic [63:0] sm_word;
    logic [63:0] mul_in, mul_c, pll, rot;
    logic [31:0] px;
    logic [64:0] rem_sh;
    logic [63:0] rng, s2x, s3x;

    assign rng = {32'd0, i_high_end - i_low_end} + 64'd1;
    assign sm_word = r_z ^ (r_z >> 31);
    assign mul_in = (r_sm_ph == 3'd1) ? (r_acc ^ (r_acc >> 30)) : (r_z ^ (r_z >> 27));
    assign mul_c = (r_sm_ph == 3'd1) ? xrng_pkg::MIX_MUL_A : xrng_pkg::MIX_MUL_B;
    assign pll = {32'd0, mul_in[31:0]} * {32'd0, mul_c[31:0]};
    assign px = mul_in[31:0] * mul_c[63:32] + mul_in[63:32] * mul_c[31:0];
    assign rot = {r_rt[56:0], r_rt[63:57]};
    assign rem_sh = {r_rem[63:0], r_dvd[63]};
    assign s2x = r_s2 ^ r_s0;
    assign s3x = r_s3 ^ r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_busy <= 1'b1;
            r_sm_ph <= 3'd0;
            r_sm_idx <= 2'd0;
            r_acc <= xrng_pkg::DEFAULT_SEED;
            r_raw_busy <= 1'b0;
            r_div_busy <= 1'b0;
            r_raw_ph <= 2'd0;
            r_dcnt <= 7'd0;
        end else begin
            if (i_cmd.load) begin
                r_act <= i_action;
                r_lo <= {32'd0, i_low_end};
                r_hi <= i_high_end;
                r_n <= (i_action == xrng_pkg::ACT_RANGE) ? rng : i_bound;
            end
            if (i_cmd.sm_start) begin
                r_sm_busy <= 1'b1;
                r_sm_ph <= 3'd0;
                r_sm_idx <= 2'd0;
                r_acc <= (i_seed == 64'd0) ? xrng_pkg::DEFAULT_SEED : i_seed;
            end else if (r_sm_busy) begin
                case (r_sm_ph)
                    3'd0: begin
                        r_acc <= r_acc + xrng_pkg::GOLDEN_INC;
                        r_sm_ph <= 3'd1;
                    end
                    3'd1, 3'd3: begin
                        r_pll <= pll;
                        r_px <= px;
                        r_sm_ph <= r_sm_ph + 3'd1;
                    end
                    3'd2, 3'd4: begin
                        r_z <= r_pll + {r_px, 32'd0};
                        r_sm_ph <= r_sm_ph + 3'd1;
                    end
                    default: begin
                        case (r_sm_idx)
                            2'd0: r_s0 <= sm_word;
                            2'd1: r_s1 <= sm_word;
                            2'd2: r_s2 <= sm_word;
                            default: r_s3 <= sm_word;
                        endcase
                        r_sm_idx <= r_sm_idx + 2'd1;
                        r_sm_ph <= 3'd0;
                        if (r_sm_idx == 2'd3) r_sm_busy <= 1'b0;
                    end
                endcase
            end
            if (i_cmd.raw_start) begin
                r_raw_busy <= 1'b1;
                r_raw_ph <= 2'd0;
            end else if (r_raw_busy) begin
                case (r_raw_ph)
                    2'd0: begin
                        r_rt <= r_s1 + (r_s1 << 2);
                        r_raw_ph <= 2'd1;
                    end
                    default: begin
                        r_x <= rot + (rot << 3);
                        r_s2 <= s2x ^ (r_s1 << 17);
                        r_s1 <= r_s1 ^ s2x;
                        r_s0 <= r_s0 ^ s3x;
                        r_s3 <= {s3x[18:0], s3x[63:19]};
                        r_raw_busy <= 1'b0;
                    end
                endcase
            end
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_dcnt <= 7'd0;
                r_rem <= 65'd0;
                r_dvd <= i_cmd.div_floor ? (64'd0 - r_n) : r_x;
            end else if (r_div_busy) begin
                if (rem_sh >= {1'b0, r_n}) r_rem <= rem_sh - {1'b0, r_n};
                else r_rem <= rem_sh;
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_dcnt <= r_dcnt + 7'd1;
                if (r_dcnt == 7'd63) r_div_busy <= 1'b0;
            end
            if (i_cmd.out_zero) o_value <= 64'd0;
            else if (i_cmd.out_lo) o_value <= r_lo;
            else if (i_cmd.out_raw) o_value <= r_x;
            else if (i_cmd.out_mod) begin
                o_value <= r_rem[63:0] + ((r_act == xrng_pkg::ACT_RANGE) ? r_lo : 64'd0);
            end
        end
    end

    always_comb begin
        o_stat.busy = r_sm_busy | r_raw_busy | r_div_busy;
        o_stat.bound_zero = (r_n == 64'd0);
        o_stat.range_empty = (r_act == xrng_pkg::ACT_RANGE) && (r_hi <= r_lo[31:0]);
        o_stat.reject = r_x < r_rem[63:0];
        o_stat.is_reseed = (r_act == xrng_pkg::ACT_RESEED);
        o_stat.is_raw = (r_act == xrng_pkg::ACT_RAW);
    end
endmodule
`default_nettype wire

@@ rtl/core/xrng_ctrl.sv @@
`default_nettype none
module xrng_ctrl (
    input wire logic i_clk,
    input wire logic i_rst_n,
    xrng_req_if.sink req,
    xrng_res_if.source res,
    input wire logic i_empty,
    input xrng_pkg::t_stat i_stat,
    output xrng_pkg::t_cmd o_cmd
);
    localparam logic [2:0] ST_BOOT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_FLOOR = 3'd3;
    localparam logic [2:0] ST_DRAW = 3'd4;
    localparam logic [2:0] ST_MOD = 3'd5;
    localparam logic [2:0] ST_WAIT = 3'd6;
    localparam logic [2:0] ST_OUT = 3'd7;

    logic [2:0] r_state, n_state;
    logic r_valid, n_valid;

    assign req.ready = (r_state == ST_IDLE) && !r_valid;
    assign res.valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !res.ready;
        o_cmd = '0;
        case (r_state)
            ST_BOOT: if (!i_stat.busy) n_state = ST_IDLE;
            ST_IDLE: begin
                if (req.valid && req.ready) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_stat.is_reseed) begin
                    o_cmd.sm_start = 1'b1;
                    n_state = ST_WAIT;
                end else if (i_stat.is_raw) begin
                    o_cmd.raw_start = 1'b1;
                    n_state = ST_WAIT;
                end else if (i_empty || i_stat.bound_zero) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_floor = 1'b1;
                    n_state = ST_FLOOR;
                end
            end
            ST_FLOOR: if (!i_stat.busy) begin
                o_cmd.raw_start = 1'b1;
                n_state = ST_DRAW;
            end
            ST_DRAW: if (!i_stat.busy) begin
                if (i_stat.reject) o_cmd.raw_start = 1'b1;
                else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: if (!i_stat.busy) begin
                o_cmd.out_mod = 1'b1;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_WAIT: if (!i_stat.busy) begin
                o_cmd.out_zero = i_stat.is_reseed;
                o_cmd.out_raw = i_stat.is_raw;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_OUT: begin
                o_cmd.out_zero = !i_empty;
                o_cmd.out_lo = i_empty;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BOOT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken twice");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !res.ready) |=> r_valid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.raw_start |-> !o_cmd.div_start)
        else $error("units started together");
endmodule
`default_nettype wire
